>>> rtl/motor_impedance_command_frame_packer_defines.svh
// assertion macros used by the frame packer top module
`ifndef MOTOR_IMPEDANCE_COMMAND_FRAME_PACKER_DEFINES_SVH
`define MOTOR_IMPEDANCE_COMMAND_FRAME_PACKER_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define MICFP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, checked on clk outside reset
`define MICFP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/micfp_pkg.sv
// types and constants of the frame packer
package micfp_pkg;

	localparam int POS_BITS   = 16;
	localparam int GAIN_BITS  = 12;
	localparam int LIM_W      = 31;
	localparam int SPAN_W     = 32;
	localparam int DIFF_W     = 33;
	localparam int PROD_W     = 48;
	localparam int ID_W       = 11;
	localparam int VAL_W      = 32;
	localparam int PAYLOAD_W  = 64;
	localparam int CFG_IDX_W  = 3;
	// front stages: difference, product, range check; then one stage per code bit
	localparam int LANE_DEPTH = 3 + POS_BITS;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POSITION  = 3'd0,
		REG_VELOCITY  = 3'd1,
		REG_TORQUE    = 3'd2,
		REG_STIFFNESS = 3'd3,
		REG_DAMPING   = 3'd4
	} cfg_reg_t;

	localparam logic [LIM_W-1:0] POSITION_RST  = 31'd819200;
	localparam logic [LIM_W-1:0] VELOCITY_RST  = 31'd2949120;
	localparam logic [LIM_W-1:0] TORQUE_RST    = 31'd1179648;
	localparam logic [LIM_W-1:0] STIFFNESS_RST = 31'd32768000;
	localparam logic [LIM_W-1:0] DAMPING_RST   = 31'd327680;

	typedef struct packed {
		logic [ID_W-1:0]         target_id;
		logic signed [VAL_W-1:0] position_cmd;
		logic signed [VAL_W-1:0] velocity_cmd;
		logic signed [VAL_W-1:0] stiffness_cmd;
		logic signed [VAL_W-1:0] damping_cmd;
		logic signed [VAL_W-1:0] torque_cmd;
	} cmd_t;

	typedef struct packed {
		logic [ID_W-1:0]      frame_id;
		logic [PAYLOAD_W-1:0] frame_payload;
		logic                 clamped;
	} frame_t;

endpackage

>>> rtl/micfp_lane.sv
// one quantizer lane: offset, scale, range check and a pipelined restoring divider
module micfp_lane #(
	parameter int BITS = 12,
	parameter bit SYM  = 1'b1
) (
	input  logic                                 clk,
	input  logic [micfp_pkg::LANE_DEPTH-1:0]     adv,
	input  logic signed [micfp_pkg::VAL_W-1:0]   x,
	input  logic [micfp_pkg::LIM_W-1:0]          lim,
	output logic [BITS-1:0]                      code,
	output logic                                 sat
);

	localparam int SW  = micfp_pkg::SPAN_W;
	localparam int PW  = micfp_pkg::PROD_W;
	localparam int DW  = micfp_pkg::DIFF_W;
	localparam int PAD = micfp_pkg::POS_BITS - BITS;

	logic [micfp_pkg::LIM_W-1:0] lim_nz;
	logic [SW-1:0]               span;

	logic [DW-1:0]   diff_s1;
	logic [PW-1:0]   prod_s2;
	logic            neg_s2;

	logic [SW-1:0]   rem_s [0:BITS];
	logic [BITS-1:0] low_s [0:BITS];
	logic [BITS-1:0] quo_s [0:BITS];
	logic            neg_s [0:BITS];
	logic            hi_s  [0:BITS];

	logic [BITS+1:0] dly_s [0:PAD];

	// user changes limits only while idle (unchecked); no stage keeps a copy of them
	assign lim_nz = (lim == '0) ? micfp_pkg::LIM_W'(1) : lim;
	assign span   = SYM ? {lim_nz, 1'b0} : {1'b0, lim_nz};

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			if (SYM)
				diff_s1 <= {x[micfp_pkg::VAL_W-1], x} + DW'(lim_nz);
			else
				diff_s1 <= {x[micfp_pkg::VAL_W-1], x};
		end
		if (adv[1]) begin
			neg_s2  <= diff_s1[DW-1];
			// diff * (2^bits - 1)
			prod_s2 <= PW'({diff_s1[SW-1:0], {BITS{1'b0}}}) - PW'(diff_s1[SW-1:0]);
		end
		if (adv[2]) begin
			neg_s[0] <= neg_s2;
			hi_s[0]  <= prod_s2 >= PW'({span, {BITS{1'b0}}});
			rem_s[0] <= prod_s2[BITS +: SW];
			low_s[0] <= prod_s2[BITS-1:0];
			quo_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < BITS; k++) begin : g_step
		logic [SW:0] trial;
		logic        ge;
		logic [SW:0] diff;

		assign trial = {rem_s[k], low_s[k][BITS-1]};
		assign ge    = trial >= {1'b0, span};
		assign diff  = trial - {1'b0, span};

		always_ff @(posedge clk) begin
			if (adv[3+k]) begin
				rem_s[k+1] <= ge ? diff[SW-1:0] : trial[SW-1:0];
				low_s[k+1] <= low_s[k] << 1;
				quo_s[k+1] <= {quo_s[k][BITS-2:0], ge};
				neg_s[k+1] <= neg_s[k];
				hi_s[k+1]  <= hi_s[k];
			end
		end
	end

	// narrow lanes wait so all lanes leave together
	assign dly_s[0] = {neg_s[BITS], hi_s[BITS], quo_s[BITS]};

	for (genvar j = 0; j < PAD; j++) begin : g_dly
		always_ff @(posedge clk) begin
			if (adv[3+BITS+j])
				dly_s[j+1] <= dly_s[j];
		end
	end

	always_comb begin
		sat = dly_s[PAD][BITS+1] | dly_s[PAD][BITS];
		if (dly_s[PAD][BITS+1])
			code = '0;
		else if (dly_s[PAD][BITS])
			code = '1;
		else
			code = dly_s[PAD][BITS-1:0];
	end

endmodule

>>> rtl/motor_impedance_command_frame_packer.sv
// Motor command frame packer. Each command word is quantized into five codes and
// packed big-endian into an 8-byte frame with the target id. One command enters
// per clock while the input is not stalled; a frame leaves through the output
// register after its command passes three front stages (offset, scale by
// 2^bits - 1, range check) and sixteen divider stages that each resolve one
// quotient bit against the configured span; narrower codes wait in the last ones.
// The input stalls only when every stage holds a word and the output is stalled.
// Limit registers are written through the cfg port, which is always ready; write
// them only while no command is in flight.
module motor_impedance_command_frame_packer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  micfp_pkg::cmd_t                     cmd,
	output logic                                frame_valid,
	input  logic                                frame_stall,
	output micfp_pkg::frame_t                   frame,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [micfp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [micfp_pkg::LIM_W-1:0]         cfg_data
);

	`include "motor_impedance_command_frame_packer_defines.svh"

	localparam int D  = micfp_pkg::LANE_DEPTH;
	localparam int PB = micfp_pkg::POS_BITS;
	localparam int GB = micfp_pkg::GAIN_BITS;

	logic [micfp_pkg::LIM_W-1:0] pos_lim_q, vel_lim_q, tq_lim_q, kp_lim_q, kd_lim_q;

	logic [D-1:0]             vld_s;
	logic [D-1:0]             adv;
	logic                     out_en;
	logic [micfp_pkg::ID_W-1:0] id_s [0:D-1];

	logic [PB-1:0] pos_code;
	logic [GB-1:0] vel_code, kp_code, kd_code, tq_code;
	logic          pos_sat, vel_sat, kp_sat, kd_sat, tq_sat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_lim_q <= micfp_pkg::POSITION_RST;
			vel_lim_q <= micfp_pkg::VELOCITY_RST;
			tq_lim_q  <= micfp_pkg::TORQUE_RST;
			kp_lim_q  <= micfp_pkg::STIFFNESS_RST;
			kd_lim_q  <= micfp_pkg::DAMPING_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				micfp_pkg::REG_POSITION:  pos_lim_q <= cfg_data;
				micfp_pkg::REG_VELOCITY:  vel_lim_q <= cfg_data;
				micfp_pkg::REG_TORQUE:    tq_lim_q  <= cfg_data;
				micfp_pkg::REG_STIFFNESS: kp_lim_q  <= cfg_data;
				micfp_pkg::REG_DAMPING:   kd_lim_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or its word moves on
	assign out_en = !frame_valid || !frame_stall;

	always_comb begin
		adv[D-1] = !vld_s[D-1] || out_en;
		for (int i = D - 2; i >= 0; i--)
			adv[i] = !vld_s[i] || adv[i+1];
	end

	assign cmd_stall = !adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			frame_valid <= 1'b0;
		end else begin
			if (adv[0])
				vld_s[0] <= cmd_valid;
			for (int i = 1; i < D; i++)
				if (adv[i])
					vld_s[i] <= vld_s[i-1];
			if (out_en)
				frame_valid <= vld_s[D-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0])
			id_s[0] <= cmd.target_id;
		for (int i = 1; i < D; i++)
			if (adv[i])
				id_s[i] <= id_s[i-1];
		if (out_en) begin
			frame.frame_id      <= id_s[D-1];
			frame.frame_payload <= {pos_code, vel_code, kp_code, kd_code, tq_code};
			frame.clamped       <= pos_sat | vel_sat | kp_sat | kd_sat | tq_sat;
		end
	end

	micfp_lane #(.BITS(PB), .SYM(1'b1)) u_pos (
		.clk(clk), .adv(adv), .x(cmd.position_cmd), .lim(pos_lim_q),
		.code(pos_code), .sat(pos_sat)
	);

	micfp_lane #(.BITS(GB), .SYM(1'b1)) u_vel (
		.clk(clk), .adv(adv), .x(cmd.velocity_cmd), .lim(vel_lim_q),
		.code(vel_code), .sat(vel_sat)
	);

	micfp_lane #(.BITS(GB), .SYM(1'b0)) u_kp (
		.clk(clk), .adv(adv), .x(cmd.stiffness_cmd), .lim(kp_lim_q),
		.code(kp_code), .sat(kp_sat)
	);

	micfp_lane #(.BITS(GB), .SYM(1'b0)) u_kd (
		.clk(clk), .adv(adv), .x(cmd.damping_cmd), .lim(kd_lim_q),
		.code(kd_code), .sat(kd_sat)
	);

	micfp_lane #(.BITS(GB), .SYM(1'b1)) u_tq (
		.clk(clk), .adv(adv), .x(cmd.torque_cmd), .lim(tq_lim_q),
		.code(tq_code), .sat(tq_sat)
	);

	`MICFP_ASSERT_NEXT(a_accept_enters, cmd_valid && !cmd_stall, vld_s[0])
	`MICFP_ASSERT_NOW(a_stall_only_full, cmd_stall, (&vld_s) && frame_valid && frame_stall)
	`MICFP_ASSERT_NEXT(a_drain, frame_valid && !frame_stall && !vld_s[D-1], !frame_valid)

endmodule

>>> bench/motor_impedance_command_frame_packer_tb.sv
// testbench of the motor command frame packer: directed table, random commands, scoreboard
`timescale 1ns / 1ps

module motor_impedance_command_frame_packer_tb;

	localparam int LATENCY   = 20;
	localparam int WDOG_MAX  = 5000;
	localparam int N_RANDOM  = 1250;
	localparam logic [15:0] POS_FULL  = 16'hFFFF;
	localparam logic [11:0] GAIN_FULL = 12'hFFF;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	micfp_pkg::cmd_t cmd;
	logic frame_valid;
	logic frame_stall;
	micfp_pkg::frame_t frame;
	logic cfg_valid;
	logic cfg_ready;
	logic [micfp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [micfp_pkg::LIM_W-1:0] cfg_data;

	// limits as the block should hold them
	logic [micfp_pkg::LIM_W-1:0] lim_pos, lim_vel, lim_tq, lim_kp, lim_kd;

	micfp_pkg::frame_t frames_due[$];
	int failures = 0;
	int idle_cycles = 0;
	int n_sent = 0;
	bit hold_off;
	bit quiet;

	typedef struct {
		micfp_pkg::cmd_t c;
		bit known;
		micfp_pkg::frame_t f;
	} vector_t;

	motor_impedance_command_frame_packer i_dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.frame_valid(frame_valid), .frame_stall(frame_stall), .frame(frame),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [15:0] code_of(input logic signed [31:0] x,
			input logic [micfp_pkg::LIM_W-1:0] lim, input bit symm, input int bits,
			inout bit sat);
		longint lo, diff;
		longint unsigned span, full, q;
		longint unsigned l;
		begin
			l = (lim == 0) ? 64'd1 : 64'(lim);
			lo = symm ? -longint'(l) : 64'sd0;
			span = symm ? 2 * l : l;
			full = (64'd1 << bits) - 1;
			diff = longint'(x) - lo;
			if (diff < 0) begin
				sat = 1'b1;
				return 16'd0;
			end
			q = (longint'(diff) * full) / span;
			if (q > full) begin
				sat = 1'b1;
				return 16'(full);
			end
			return 16'(q);
		end
	endfunction

	function automatic micfp_pkg::frame_t pack_frame(input micfp_pkg::cmd_t c);
		micfp_pkg::frame_t f;
		bit sat;
		logic [15:0] p, v, kp, kd, tq;
		begin
			sat = 1'b0;
			p  = code_of(c.position_cmd, lim_pos, 1, 16, sat);
			v  = code_of(c.velocity_cmd, lim_vel, 1, 12, sat);
			kp = code_of(c.stiffness_cmd, lim_kp, 0, 12, sat);
			kd = code_of(c.damping_cmd, lim_kd, 0, 12, sat);
			tq = code_of(c.torque_cmd, lim_tq, 1, 12, sat);
			f.frame_id = c.target_id;
			f.frame_payload = {p, v[11:0], kp[11:0], kd[11:0], tq[11:0]};
			f.clamped = sat;
			return f;
		end
	endfunction

	// one write, then valid drops so writes never follow back to back
	task automatic write_limit(input micfp_pkg::cfg_reg_t idx,
			input logic [micfp_pkg::LIM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			micfp_pkg::REG_POSITION:  lim_pos = val;
			micfp_pkg::REG_VELOCITY:  lim_vel = val;
			micfp_pkg::REG_TORQUE:    lim_tq = val;
			micfp_pkg::REG_STIFFNESS: lim_kp = val;
			micfp_pkg::REG_DAMPING:   lim_kd = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain;
		cmd_valid <= 1'b0;
		while (frames_due.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// one word offered until taken; expected frame queued on acceptance
	task automatic send_cmd(input micfp_pkg::cmd_t c, input bit known,
			input micfp_pkg::frame_t f);
		while (!quiet && $urandom_range(99) < 7) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		frames_due.push_back(known ? f : pack_frame(c));
	endtask

	function automatic logic [31:0] pick_val(input logic [micfp_pkg::LIM_W-1:0] lim,
			input bit symm);
		int r;
		logic [31:0] l;
		begin
			l = {1'b0, lim};
			r = $urandom_range(99);
			if (r < 10) return $urandom;
			if (r < 15) return symm ? -l : 32'd0;
			if (r < 20) return l;
			if (r < 25) return l + $urandom_range(3);
			if (r < 30) return (symm ? -l : 32'd0) - $urandom_range(3);
			if (symm) return 32'($signed({1'b0, $urandom}) % (2 * longint'(l) + 1)) - l;
			return 32'(longint'($urandom) % (longint'(l) + 1));
		end
	endfunction

	function automatic micfp_pkg::cmd_t rand_cmd;
		micfp_pkg::cmd_t c;
		begin
			c.target_id = 11'($urandom);
			c.position_cmd = pick_val(lim_pos, 1);
			c.velocity_cmd = pick_val(lim_vel, 1);
			c.stiffness_cmd = pick_val(lim_kp, 0);
			c.damping_cmd = pick_val(lim_kd, 0);
			c.torque_cmd = pick_val(lim_tq, 1);
			return c;
		end
	endfunction

	function automatic logic [micfp_pkg::LIM_W-1:0] rand_limit;
		int r;
		begin
			r = $urandom_range(9);
			if (r == 0) return 31'd1;
			if (r == 1) return 31'h7FFFFFFF;
			if (r == 2) return 31'd0;
			if (r < 6) return micfp_pkg::LIM_W'($urandom_range(1, 32'h00FFFFFF));
			return micfp_pkg::LIM_W'($urandom);
		end
	endfunction

	// frame side: random stall, one long hold-off, scoreboard
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_stall <= 1'b0;
		end else begin
			frame_stall <= hold_off || (!quiet && $urandom_range(99) < 7);
			if (frame_valid && !frame_stall) begin
				if (frames_due.size() == 0) begin
					$error("frame with none expected: %h", frame);
					failures++;
				end else begin
					micfp_pkg::frame_t e;
					e = frames_due.pop_front();
					if (frame.frame_id !== e.frame_id) begin
						$error("frame_id: expected %h, got %h", e.frame_id, frame.frame_id);
						failures++;
					end
					if (frame.frame_payload !== e.frame_payload) begin
						$error("frame_payload: expected %h, got %h",
							e.frame_payload, frame.frame_payload);
						failures++;
					end
					if (frame.clamped !== e.clamped) begin
						$error("clamped: expected %b, got %b", e.clamped, frame.clamped);
						failures++;
					end
				end
			end
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (frame_valid && !frame_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WDOG_MAX) begin
			$display("[motor_impedance_command_frame_packer] ERROR");
			$finish;
		end
	end

	// long receiver hold-off, counted here, in the middle of the unbroken random phase
	initial begin
		hold_off = 1'b0;
		wait (arst_n);
		wait (n_sent >= 200);
		hold_off = 1'b1;
		repeat (150) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		vector_t tbl[$];
		micfp_pkg::cmd_t c;
		micfp_pkg::frame_t z;
		quiet = 1'b0;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		lim_pos = micfp_pkg::POSITION_RST;
		lim_vel = micfp_pkg::VELOCITY_RST;
		lim_tq = micfp_pkg::TORQUE_RST;
		lim_kp = micfp_pkg::STIFFNESS_RST;
		lim_kd = micfp_pkg::DAMPING_RST;
		z = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all at low end: codes zero, no clamp
		c = '{11'h7FF, -32'sd819200, -32'sd2949120, 32'sd0, 32'sd0, -32'sd1179648};
		tbl.push_back('{c, 1, '{11'h7FF, 64'd0, 1'b0}});
		// all at high end: full scale, no clamp
		c = '{11'h000, 32'sd819200, 32'sd2949120, 32'sd32768000, 32'sd327680, 32'sd1179648};
		tbl.push_back('{c, 1, '{11'h000,
			{POS_FULL, GAIN_FULL, GAIN_FULL, GAIN_FULL, GAIN_FULL}, 1'b0}});
		// below range everywhere
		c = '{11'h555, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000};
		tbl.push_back('{c, 1, '{11'h555, 64'd0, 1'b1}});
		// above range everywhere
		c = '{11'h2AA, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
		tbl.push_back('{c, 1, '{11'h2AA,
			{POS_FULL, GAIN_FULL, GAIN_FULL, GAIN_FULL, GAIN_FULL}, 1'b1}});
		// single field just outside, then two commands inside the range
		tbl.push_back('{'{11'h001, 32'sd819201, 0, 0, 0, 0}, 0, z});
		tbl.push_back('{'{11'h002, 0, -32'sd2949121, 0, 0, 0}, 0, z});
		tbl.push_back('{'{11'h003, 0, 0, -32'sd1, 0, 0}, 0, z});
		tbl.push_back('{'{11'h004, 0, 0, 0, 32'sd327681, 0}, 0, z});
		tbl.push_back('{'{11'h005, 0, 0, 0, 0, -32'sd1179649}, 0, z});
		tbl.push_back('{'{11'h123, 0, 0, 0, 0, 0}, 0, z});
		tbl.push_back('{'{11'h400, 32'sd12345, -32'sd777, 32'sd1000, 32'sd99, 32'sd1}, 0, z});
		foreach (tbl[i]) send_cmd(tbl[i].c, tbl[i].known, tbl[i].f);
		drain();

		// zero limits act as one; an unknown index changes nothing
		write_limit(micfp_pkg::REG_POSITION, 31'd0);
		write_limit(micfp_pkg::REG_VELOCITY, 31'd0);
		write_limit(micfp_pkg::REG_TORQUE, 31'd0);
		write_limit(micfp_pkg::REG_STIFFNESS, 31'd0);
		write_limit(micfp_pkg::REG_DAMPING, 31'd0);
		write_limit(micfp_pkg::cfg_reg_t'(3'd7), 31'd5);
		write_limit(micfp_pkg::cfg_reg_t'(3'd5), 31'h7FFFFFFF);
		for (int i = 0; i < 6; i++) begin
			c = '{11'(i), 32'(i - 3), 32'(i - 2), 32'(i - 1), 32'(i), 32'(3 - i)};
			send_cmd(c, 0, z);
		end
		drain();
		// widest span
		write_limit(micfp_pkg::REG_POSITION, 31'h7FFFFFFF);
		write_limit(micfp_pkg::REG_VELOCITY, 31'h7FFFFFFF);
		write_limit(micfp_pkg::REG_TORQUE, 31'h7FFFFFFF);
		write_limit(micfp_pkg::REG_STIFFNESS, 31'h7FFFFFFF);
		write_limit(micfp_pkg::REG_DAMPING, 31'h7FFFFFFF);
		send_cmd('{11'h7FF, 32'h80000000, 32'h80000001, 32'h7FFFFFFF, 0, 32'h80000001}, 0, z);
		send_cmd('{11'h0, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h80000000, 32'h1, 32'h0}, 0, z);
		drain();

		// random phases, each after the first with fresh limits; the second with no idling
		for (int ph = 0; n_sent < N_RANDOM; ph++) begin
			if (ph > 0) begin
				write_limit(micfp_pkg::REG_POSITION, rand_limit());
				write_limit(micfp_pkg::REG_VELOCITY, rand_limit());
				write_limit(micfp_pkg::REG_TORQUE, rand_limit());
				write_limit(micfp_pkg::REG_STIFFNESS, rand_limit());
				write_limit(micfp_pkg::REG_DAMPING, rand_limit());
			end
			quiet = (ph == 1);
			for (int k = 0; k < 150 && n_sent < N_RANDOM; k++, n_sent++)
				send_cmd(rand_cmd(), 0, z);
			// sender pause until all frames are back
			drain();
		end
		quiet = 1'b0;
		drain();

		if (failures == 0)
			$display("[motor_impedance_command_frame_packer] OK");
		else
			$display("[motor_impedance_command_frame_packer] ERROR");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/micfp_pkg.sv
rtl/micfp_lane.sv
rtl/motor_impedance_command_frame_packer.sv
bench/motor_impedance_command_frame_packer_tb.sv
